// ----- src/ovle_pkg.sv -----
// Shared types and constants for the ordered value list engine.
// No dependencies.
`timescale 1ns / 1ps

package ovle_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int ACT_W     = 3;
    localparam int VAL_W     = 64;
    localparam int POS_W     = 16;
    localparam int OUT_W     = 5;

    localparam logic [ACT_W-1:0] ACT_ADD     = 3'd0;
    localparam logic [ACT_W-1:0] ACT_INSERT  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_MEMBER  = 3'd2;
    localparam logic [ACT_W-1:0] ACT_SEARCH  = 3'd3;
    localparam logic [ACT_W-1:0] ACT_REVERSE = 3'd4;

    localparam logic [OUT_W-1:0] NO_INDEX = '1;

    // per-cell control issued by the sequencer in the execute cycle
    typedef struct packed {
        logic             ins_en;   // shift/insert pass
        logic             rev_en;   // mirror swap pass
        logic [VAL_W-1:0] value;
    } cell_ctrl_t;

    // IEEE double equality: +0 == -0, NaN never equal
    function automatic logic dbl_eq(input logic [VAL_W-1:0] a, input logic [VAL_W-1:0] b);
        logic a_nan;
        logic b_nan;
        a_nan = (a[62:52] == 11'h7ff) && (a[51:0] != '0);
        b_nan = (b[62:52] == 11'h7ff) && (b[51:0] != '0);
        dbl_eq = !a_nan && !b_nan &&
                 ((a == b) || ((a[62:0] == '0) && (b[62:0] == '0)));
    endfunction

endpackage

// ----- src/ovle_cell.sv -----
// One list cell: holds an entry, shifts from its front neighbor on insert,
// takes its mirror partner on reverse, and compares against the probe.
// Depends on ovle_pkg.
`timescale 1ns / 1ps

module ovle_cell
(
    input  logic                     clk,
    input  ovle_pkg::cell_ctrl_t     ctrl,
    input  logic                     take_new,   // this cell is the insert slot
    input  logic                     take_prev,  // this cell is behind the slot
    input  logic                     take_mir,   // reverse swaps this cell
    input  logic [ovle_pkg::VAL_W-1:0] prev_val,
    input  logic [ovle_pkg::VAL_W-1:0] mir_val,
    output logic [ovle_pkg::VAL_W-1:0] val,
    output logic                     hit
);
    import ovle_pkg::*;

    logic [VAL_W-1:0] val_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.ins_en && take_new)
        begin
            val_reg <= ctrl.value;
        end
        else if (ctrl.ins_en && take_prev)
        begin
            val_reg <= prev_val;
        end
        else if (ctrl.rev_en && take_mir)
        begin
            val_reg <= mir_val;
        end
    end

    assign val = val_reg;
    assign hit = dbl_eq(val_reg, ctrl.value);

endmodule

// ----- src/ordered_value_list_engine.sv -----
// Ordered value list engine: a chain of DEPTH cells holding IEEE doubles.
// After a request is accepted, decode and execute share the busy cycle and
// the result registers load at its end, along with result valid. A new
// request is not taken while one is in flight; the next is taken once the
// result register is free. All cells compare or shift in parallel.
// Reset (rst_n, async low) empties the list; cell contents are not cleared.
`timescale 1ns / 1ps

module ordered_value_list_engine
#(
    parameter int DEPTH = ovle_pkg::DEPTH_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [ovle_pkg::ACT_W-1:0] action,
    input  logic [ovle_pkg::VAL_W-1:0] item_value,
    input  logic signed [ovle_pkg::POS_W-1:0] position,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic                       found,
    output logic signed [ovle_pkg::OUT_W-1:0] found_index,
    output logic                       status,
    output logic [ovle_pkg::OUT_W-1:0] entry_count
);
    import ovle_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);

    // request holding register
    logic             busy_reg;
    logic [ACT_W-1:0] act_reg;
    logic [VAL_W-1:0] val_reg;
    logic [POS_W-1:0] pos_reg;
    logic [CW-1:0]    count_reg;

    logic             found_reg;
    logic [OUT_W-1:0] index_reg;
    logic             status_reg;
    logic             out_valid_reg;

    assign in_ready = !busy_reg && !out_valid_reg;

    // decode
    logic       is_ins;
    logic       full;
    logic [CW-1:0] slot;
    logic       do_ins;
    always_comb
    begin
        is_ins = (act_reg == ACT_ADD) || (act_reg == ACT_INSERT);
        full   = (count_reg >= CW'(DEPTH));
        if (act_reg == ACT_ADD || pos_reg == '0 || count_reg == '0)
        begin
            slot = '0;
        end
        else if (pos_reg[POS_W-1])
        begin
            slot = CW'(1);
        end
        else if ({16'b0, pos_reg} > 32'(count_reg))
        begin
            slot = count_reg;
        end
        else
        begin
            slot = CW'(pos_reg);
        end
        do_ins = busy_reg && is_ins && !full;
    end

    cell_ctrl_t ctrl;
    assign ctrl.ins_en = do_ins;
    assign ctrl.rev_en = busy_reg && (act_reg == ACT_REVERSE);
    assign ctrl.value  = val_reg;

    logic [VAL_W-1:0] cell_val [DEPTH];
    logic [DEPTH-1:0] hit_vec;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            logic [VAL_W-1:0] prev_v;
            logic [CW-1:0]    mir;
            if (g == 0)
            begin : g_first
                assign prev_v = cell_val[0];
            end
            else
            begin : g_rest
                assign prev_v = cell_val[g-1];
            end
            // mirror index count-1-g, valid only inside the list
            assign mir = count_reg - CW'(1) - CW'(g);
            ovle_cell u_cell
            (
                .clk       (clk),
                .ctrl      (ctrl),
                .take_new  (CW'(g) == slot),
                .take_prev (CW'(g) > slot && CW'(g) <= count_reg),
                .take_mir  (CW'(g) < count_reg),
                .prev_val  (prev_v),
                .mir_val   (cell_val[mir[IW-1:0]]),
                .val       (cell_val[g]),
                .hit       (hit_vec[g])
            );
        end
    endgenerate

    // first hit among valid entries
    logic [DEPTH-1:0] hit_ok;
    logic [OUT_W-1:0] first_idx;
    logic             any_hit;
    always_comb
    begin
        first_idx = NO_INDEX;
        any_hit   = 1'b0;
        for (int k = DEPTH - 1; k >= 0; k--)
        begin
            hit_ok[k] = hit_vec[k] && (CW'(k) < count_reg);
            if (hit_ok[k])
            begin
                first_idx = OUT_W'(k);
                any_hit   = 1'b1;
            end
        end
    end

    logic is_look;
    assign is_look = (act_reg == ACT_MEMBER) || (act_reg == ACT_SEARCH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                busy_reg      <= 1'b0;
                out_valid_reg <= 1'b1;
                if (do_ins)
                begin
                    count_reg <= count_reg + CW'(1);
                end
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            act_reg <= action;
            val_reg <= item_value;
            pos_reg <= position;
        end
        if (busy_reg)
        begin
            found_reg  <= is_look && any_hit;
            index_reg  <= is_look ? first_idx : NO_INDEX;
            status_reg <= is_ins && full;
        end
    end

    assign out_valid   = out_valid_reg;
    assign found       = found_reg;
    assign found_index = index_reg;
    assign status      = status_reg;
    assign entry_count = OUT_W'(count_reg);

    // count never passes the depth
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= CW'(DEPTH))
        else $error("count over depth");
    // full list rejects inserts and keeps its count
    assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && is_ins && full |=> status_reg && $stable(count_reg))
        else $error("insert on full list changed count");
    // found matches index sign
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (found_reg == (index_reg != NO_INDEX)))
        else $error("found and index disagree");

endmodule

// ----- tb/sv/ordered_value_list_engine_test.sv -----
// Self-checking testbench for the ordered value list engine.
// Depends on ovle_pkg and ordered_value_list_engine; a local list model predicts each result.
`timescale 1ns / 1ps

module ordered_value_list_engine_test;

    import ovle_pkg::*;

    localparam int LIST_DEPTH = DEPTH_DEF;
    localparam int CYCLE_LIMIT = 400000;

    // Canned doubles used by the directed and random tests
    localparam logic [VAL_W-1:0] POS_ZERO = 64'h0000_0000_0000_0000;
    localparam logic [VAL_W-1:0] NEG_ZERO = 64'h8000_0000_0000_0000;
    localparam logic [VAL_W-1:0] QNAN     = 64'h7ff8_0000_0000_0000;
    localparam logic [VAL_W-1:0] SNAN     = 64'hfff0_0000_0000_0001;
    localparam logic [VAL_W-1:0] POS_INF  = 64'h7ff0_0000_0000_0000;
    localparam logic [VAL_W-1:0] ONE      = 64'h3ff0_0000_0000_0000;

    typedef struct packed {
        logic                    found;
        logic signed [OUT_W-1:0] found_index;
        logic                    status;
        logic [OUT_W-1:0]        entry_count;
    } list_reply_t;

    logic                    clk;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_ready;
    logic [ACT_W-1:0]        action;
    logic [VAL_W-1:0]        item_value;
    logic signed [POS_W-1:0] position;
    logic                    out_valid;
    logic                    out_ready;
    logic                    found;
    logic signed [OUT_W-1:0] found_index;
    logic                    status;
    logic [OUT_W-1:0]        entry_count;

    // Shadow copy of the list, front at index 0
    logic [VAL_W-1:0] shadow_list [LIST_DEPTH];
    int               shadow_len;
    list_reply_t      pending_replies [$];

    // Idle rates in percent; hold_off forces a long receiver stall
    int  send_idle_pct;
    int  recv_idle_pct;
    bit  hold_off;
    int  error_count;
    int  cycle_count;
    logic [VAL_W-1:0] value_pool [8];

    ordered_value_list_engine DUT
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .action      (action),
        .item_value  (item_value),
        .position    (position),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .found       (found),
        .found_index (found_index),
        .status      (status),
        .entry_count (entry_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Timeout guard
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("ordered_value_list_engine regression: fail");
                $finish;
            end
        end
    end

    // IEEE equality: NaN never matches, signed zeros match
    function automatic bit doubles_equal(logic [VAL_W-1:0] a, logic [VAL_W-1:0] b);
        bit a_nan;
        bit b_nan;
        a_nan = (a[62:52] == 11'h7ff) && (a[51:0] != 0);
        b_nan = (b[62:52] == 11'h7ff) && (b[51:0] != 0);
        if (a_nan || b_nan)
            return 1'b0;
        return (a == b) || (a[62:0] == 0 && b[62:0] == 0);
    endfunction

    function automatic void shadow_place(int idx, logic [VAL_W-1:0] value);
        for (int k = shadow_len; k > idx; k--)
            shadow_list[k] = shadow_list[k-1];
        shadow_list[idx] = value;
        shadow_len++;
    endfunction

    // Apply one request to the shadow list and return the reply it should give
    function automatic list_reply_t apply_list_command(logic [ACT_W-1:0] act,
                                                       logic [VAL_W-1:0] value,
                                                       logic signed [POS_W-1:0] pos);
        list_reply_t r;
        logic [VAL_W-1:0] tmp;
        int lo;
        int hi;
        r.found = 1'b0;
        r.found_index = NO_INDEX;
        r.status = 1'b0;
        case (act)
            ACT_ADD, ACT_INSERT:
            begin
                if (shadow_len >= LIST_DEPTH)
                    r.status = 1'b1;
                else if (act == ACT_ADD || pos == 0 || shadow_len == 0)
                    shadow_place(0, value);
                else if (pos < 0)
                    shadow_place(1, value);
                else
                    shadow_place((int'(pos) > shadow_len) ? shadow_len : int'(pos), value);
            end
            ACT_MEMBER, ACT_SEARCH:
            begin
                for (int k = 0; k < shadow_len; k++)
                begin
                    if (doubles_equal(shadow_list[k], value))
                    begin
                        r.found = 1'b1;
                        r.found_index = k[OUT_W-1:0];
                        break;
                    end
                end
            end
            ACT_REVERSE:
            begin
                lo = 0;
                hi = shadow_len - 1;
                while (lo < hi)
                begin
                    tmp = shadow_list[lo];
                    shadow_list[lo] = shadow_list[hi];
                    shadow_list[hi] = tmp;
                    lo++;
                    hi--;
                end
            end
            default: ;
        endcase
        r.entry_count = shadow_len[OUT_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        error_count++;
    endtask

    // Send one request; the prediction is made at acceptance. Valid stays
    // up after acceptance so a back-to-back request can follow in the same
    // step; the idle loop or wait_drained drops it.
    task automatic send_request(logic [ACT_W-1:0] act, logic [VAL_W-1:0] value,
                                logic signed [POS_W-1:0] pos);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        action     <= act;
        item_value <= value;
        position   <= pos;
        do
            @(posedge clk);
        while (!in_ready);
        pending_replies.push_back(apply_list_command(act, value, pos));
    endtask

    // Receiver ready pattern
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
    end

    // Result checker
    always @(posedge clk)
    begin
        list_reply_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_replies.size() == 0)
            begin
                report_mismatch("result with no request outstanding", 1, 0);
            end
            else
            begin
                want = pending_replies.pop_front();
                if (found !== want.found)
                    report_mismatch("found", found, want.found);
                if (found_index !== want.found_index)
                    report_mismatch("found_index", found_index, want.found_index);
                if (status !== want.status)
                    report_mismatch("status", status, want.status);
                if (entry_count !== want.entry_count)
                    report_mismatch("entry_count", entry_count, want.entry_count);
            end
        end
    end

    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(3))
            0: return {$urandom, $urandom};
            default: return value_pool[$urandom_range(7)];
        endcase
    endfunction

    function automatic logic signed [POS_W-1:0] pick_position();
        case ($urandom_range(5))
            0: return 16'sd0;
            1: return -$signed(16'($urandom_range(32768, 1)));
            2: return 16'($urandom);
            default: return 16'($urandom_range(LIST_DEPTH + 1));
        endcase
    endfunction

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Extremes of the fields and the named special cases
    task automatic test_directed();
        send_request(ACT_SEARCH, ONE, 16'sd0);              // empty list
        send_request(ACT_REVERSE, '0, 16'sd0);              // reverse empty
        send_request(ACT_INSERT, ONE, 16'sd5);              // empty list insert
        send_request(ACT_REVERSE, '0, 16'sd0);              // reverse single
        send_request(ACT_INSERT, POS_ZERO, 16'sh8000);      // negative position
        send_request(ACT_INSERT, QNAN, 16'sd32767);         // past the end
        send_request(ACT_ADD, 64'hffff_ffff_ffff_ffff, 16'sd0);
        send_request(ACT_INSERT, POS_INF, 16'sd0);          // position zero
        send_request(ACT_INSERT, SNAN, 16'sd2);
        send_request(ACT_MEMBER, NEG_ZERO, 16'sd0);         // -0 matches +0
        send_request(ACT_SEARCH, QNAN, 16'sd0);             // NaN never matches
        send_request(ACT_SEARCH, POS_INF, -16'sd1);
        send_request(ACT_MEMBER, 64'h0123_4567_89ab_cdef, 16'sd0);
        send_request(ACT_REVERSE, '0, -16'sd1);
        send_request(ACT_SEARCH, ONE, 16'sd0);
        send_request(3'd5, ONE, 16'sd0);                    // unknown actions
        send_request(3'd6, '0, 16'sd1);
        send_request(3'd7, 64'hffff_ffff_ffff_ffff, -16'sd1);
        // fill until full, then overflow both ways
        while (shadow_len < LIST_DEPTH)
            send_request(ACT_ADD, {$urandom, $urandom}, 16'sd0);
        send_request(ACT_ADD, ONE, 16'sd0);
        send_request(ACT_INSERT, ONE, 16'sd3);
        send_request(ACT_SEARCH, shadow_list[LIST_DEPTH-1], 16'sd0);
        send_request(ACT_REVERSE, '0, 16'sd0);
        send_request(ACT_SEARCH, shadow_list[LIST_DEPTH-1], 16'sd0);
        wait_drained();
    endtask

    // Random traffic: the list only grows, so from here on add and insert
    // always hit the full case while lookups and reversal see a full list
    task automatic test_random(int count);
        int act_roll;
        logic [ACT_W-1:0] act;
        for (int n = 0; n < count; n++)
        begin
            act_roll = $urandom_range(99);
            if (act_roll < 20)      act = ACT_ADD;
            else if (act_roll < 45) act = ACT_INSERT;
            else if (act_roll < 65) act = ACT_MEMBER;
            else if (act_roll < 85) act = ACT_SEARCH;
            else if (act_roll < 95) act = ACT_REVERSE;
            else                    act = 3'($urandom_range(7, 5));
            send_request(act, pick_value(), pick_position());
        end
        wait_drained();
    endtask

    // Receiver stalls for a long stretch while requests keep coming
    task automatic test_backpressure();
        fork
            begin
                hold_off = 1'b1;
                repeat (300) @(posedge clk);
                hold_off = 1'b0;
            end
            test_random(30);
        join
    endtask

    initial
    begin
        error_count = 0;
        hold_off = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        shadow_len = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        action = '0;
        item_value = '0;
        position = '0;
        value_pool = '{POS_ZERO, NEG_ZERO, QNAN, SNAN, POS_INF, ONE,
                       64'hbff0_0000_0000_0000, 64'h4000_0000_0000_0000};
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 36;
        recv_idle_pct = 54;
        test_directed();
        test_random(250);
        send_idle_pct = 54;
        recv_idle_pct = 36;
        test_random(250);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(250);
        test_backpressure();

        repeat (20) @(posedge clk);
        if (error_count == 0 && pending_replies.size() == 0)
            $display("ordered_value_list_engine regression: pass");
        else
            $display("ordered_value_list_engine regression: fail");
        $finish;
    end

endmodule

// ----- files.f -----
src/ovle_pkg.sv
src/ovle_cell.sv
src/ordered_value_list_engine.sv
tb/sv/ordered_value_list_engine_test.sv
